FILE: hdl/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared constants, controller states, command and status types for the
// window trend statistics block.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] PERIOD_RST = 7'd7;
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int RES_W            = 24;
    localparam int SWT_W            = 16;
    localparam int PCT_SCALE        = 100;
    localparam int SQB_W            = $clog2(RES_W);
    localparam int DRAIN_LEN        = 3;
    localparam int OUT_FW           = 3 * RES_W + 1 + SWT_W;
    localparam int OUT_DW           = ((OUT_FW + 7) / 8) * 8;
    localparam int OUT_UW           = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_MUL,
        ST_SUB,
        ST_SQ_T,
        ST_SQ_S,
        ST_SQ_C,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_RISE = 2'd1,
        TREND_FALL = 2'd2
    } t_trend;

    typedef struct packed {
        logic             load;
        logic             rd;
        logic             first;
        logic             mul;
        logic             sub;
        logic             div_start;
        logic             sq_t;
        logic             sq_s;
        logic             sq_c;
        logic [SQB_W-1:0] sq_bit;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

FILE: hdl/wts_ram.sv
// ----------------------------------------------------------------------------
// wts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/wts_div.sv
// ----------------------------------------------------------------------------
// wts_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wts_div #(
    parameter int NW = 32,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic          o_busy
);

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]   r_rem, n_rem;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_den;
    logic [DW:0]     rem_sh;
    logic [DW:0]     diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        diff   = rem_sh - {1'b0, r_den};
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_cnt = CNTW'(NW);
            n_rem = '0;
            n_quo = i_num;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (!diff[DW]) begin
                n_rem = diff[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = (r_cnt != '0);

endmodule

FILE: hdl/wts_datapath.sv
// ----------------------------------------------------------------------------
// wts_datapath
// Sample ring, window walk accumulators, variance, square root search,
// percent and rise dividers, trend tracking and the result register.
// ----------------------------------------------------------------------------
module wts_datapath #(
    parameter int WINDOW_MAX   = wts_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = wts_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wts_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    input  wts_pkg::t_cmd                      i_cmd,
    output wts_pkg::t_stat                     o_stat,
    output logic [$clog2(WINDOW_MAX+1)-1:0]    o_walk_len,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [wts_pkg::OUT_DW-1:0]         o_m_tdata,
    output logic [wts_pkg::OUT_UW-1:0]         o_m_tuser
);

    import wts_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DEPTH = WINDOW_MAX + 1;
    localparam int PW    = $clog2(WINDOW_MAX + 1);
    localparam int CW    = $clog2(WINDOW_MAX + 2);
    localparam int SSW   = SW + PW;
    localparam int QW    = 2 * SW + PW;
    localparam int DW    = 2 * SW + 2 * PW;
    localparam int D4W   = DW + 2;
    localparam int TW    = RES_W + 1 + PW;
    localparam int CMPW  = (2 * TW > D4W) ? 2 * TW : D4W;
    localparam int RSW   = SW + PW;
    localparam int RNW   = RSW + 2;
    localparam int RDW   = PW + 1;
    localparam int CNW   = SW + 9;
    localparam int CDW   = SW + 1;
    localparam int PAD_W = OUT_DW - OUT_FW;
    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};
    localparam logic [63:0] POS_LIM = (64'd1 << (RES_W - 1)) - 64'd1;
    localparam logic [63:0] NEG_LIM = 64'd1 << (RES_W - 1);
    localparam logic signed [SW+7:0] SCALE = (SW + 8)'(PCT_SCALE);

    // configuration and ring state
    logic [CFG_W-1:0]     r_period;
    logic [PW-1:0]        r_head;
    logic [CW-1:0]        r_seen;
    logic [PW-1:0]        r_raddr;
    logic signed [SW-1:0] r_x;
    logic                 r_sp_ok;
    logic                 r_more;

    // walk pipeline
    logic                 r_rv, r_rfirst;
    logic signed [SW-1:0] r_o, r_last;
    logic [RSW-1:0]       r_rsum;
    logic signed [SSW-1:0] r_s;
    logic                 r_ev;
    logic [SW-1:0]        r_emag;
    logic                 r_sqv;
    logic [2*SW-1:0]      r_sq;
    logic [QW-1:0]        r_q;

    // variance and root search
    logic [DW-1:0]        r_pq, r_ss;
    logic [D4W-1:0]       r_d4;
    logic [RES_W-1:0]     r_lo;
    logic [TW-1:0]        r_t;
    logic [2*TW-1:0]      r_tt;

    // percent sign info
    logic                 r_o_zero, r_flat, r_neg;

    // trend state and result register
    t_trend               r_trend, n_trend;
    logic [SWT_W-1:0]     r_swcnt, n_swcnt;
    logic                 r_out_valid;
    logic [RES_W-1:0]     r_rise_avg, r_pct, r_spread;
    logic                 r_switched;
    logic [OUT_UW-1:0]    r_vflags;

    logic [PW-1:0]        p;
    logic [PW-1:0]        n_head;
    logic [PW-1:0]        start_addr;
    logic [PW-1:0]        raddr_inc;
    logic [PW:0]          head_x;
    logic [CW-1:0]        n_seen, p_c;
    logic [SW-1:0]        rdata;
    logic signed [SW-1:0] e;
    logic [SW-1:0]        rise_d;
    logic [SSW-1:0]       s_mag;
    logic [RES_W-1:0]     cand;
    logic [RES_W:0]       odd;
    logic signed [SW:0]   diff;
    logic signed [SW+7:0] num;
    logic [SW+7:0]        an;
    logic [SW-1:0]        ao;
    logic [RNW-1:0]       rise_num, rise_q;
    logic [RDW-1:0]       rise_den;
    logic [CNW-1:0]       pct_num, pct_q;
    logic [CDW-1:0]       pct_den;
    logic                 busy_r, busy_c;
    logic [RES_W-1:0]     rise_sat, pct_sat;
    t_trend               cur;
    logic                 sw_now;

    // effective window length and ring pointers
    always_comb begin
        p = PW'(r_period);
        if (r_period == '0) begin
            p = PW'(1);
        end else if (32'(r_period) > WINDOW_MAX) begin
            p = PW'(WINDOW_MAX);
        end
        n_head    = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        raddr_inc = (r_raddr == PW'(DEPTH - 1)) ? '0 : r_raddr + 1'b1;
        head_x    = {1'b0, n_head};
        if (head_x >= (PW + 1)'(p)) begin
            start_addr = PW'(head_x - (PW + 1)'(p));
        end else begin
            start_addr = PW'(head_x + (PW + 1)'(DEPTH) - (PW + 1)'(p));
        end
        p_c    = CW'(p);
        n_seen = (r_seen < p_c + 1'b1) ? r_seen + 1'b1 : p_c + 1'b1;
    end

    wts_ram #(
        .WIDTH(SW),
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_waddr(n_head),
        .i_wdata(i_sample),
        .i_re   (i_cmd.rd),
        .i_raddr(r_raddr),
        .o_rdata(rdata)
    );

    assign e      = signed'(rdata);
    assign rise_d = SW'(e - r_last);
    assign s_mag  = r_s[SSW-1] ? SSW'(-r_s) : SSW'(r_s);
    assign cand   = r_lo | (RES_W'(1) << i_cmd.sq_bit);
    assign odd    = {cand, 1'b0} - 1'b1;

    // divider operands
    assign rise_num = RNW'({r_rsum, 1'b0}) + RNW'(p);
    assign rise_den = {p, 1'b0};
    assign diff     = (SW + 1)'(r_x) - (SW + 1)'(r_o);
    assign num      = (SW + 8)'(diff) * SCALE;
    assign an       = num[SW+7] ? (SW + 8)'(-num) : (SW + 8)'(num);
    assign ao       = r_o[SW-1] ? SW'(-r_o) : SW'(r_o);
    assign pct_num  = CNW'({an, 1'b0}) + CNW'(ao);
    assign pct_den  = {ao, 1'b0};

    wts_div #(
        .NW(RNW),
        .DW(RDW)
    ) u_div_rise (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (rise_num),
        .i_den  (rise_den),
        .o_quo  (rise_q),
        .o_busy (busy_r)
    );

    wts_div #(
        .NW(CNW),
        .DW(CDW)
    ) u_div_pct (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (pct_num),
        .i_den  (pct_den),
        .o_quo  (pct_q),
        .o_busy (busy_c)
    );

    // saturation and trend tracking for the finishing step
    always_comb begin
        rise_sat = (64'(rise_q) > 64'(RES_MAX)) ? RES_MAX : RES_W'(rise_q);
        if (r_o_zero) begin
            pct_sat = RES_W'(PCT_SCALE);
        end else if (r_neg) begin
            pct_sat = (64'(pct_q) > NEG_LIM) ? RES_W'(NEG_LIM)
                                             : RES_W'(64'd0 - 64'(pct_q));
        end else begin
            pct_sat = (64'(pct_q) > POS_LIM) ? RES_W'(POS_LIM) : RES_W'(pct_q);
        end
        if (r_o_zero) begin
            cur = TREND_RISE;
        end else if (r_flat) begin
            cur = TREND_NONE;
        end else if (r_neg) begin
            cur = TREND_FALL;
        end else begin
            cur = TREND_RISE;
        end
        n_trend = r_trend;
        n_swcnt = r_swcnt;
        sw_now  = 1'b0;
        if (r_more && cur != TREND_NONE) begin
            if (r_trend != TREND_NONE && cur != r_trend) begin
                n_trend = cur;
                sw_now  = 1'b1;
                if (r_swcnt != {SWT_W{1'b1}}) begin
                    n_swcnt = r_swcnt + 1'b1;
                end
            end else if (r_trend == TREND_NONE) begin
                n_trend = cur;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RST;
            r_head      <= '0;
            r_seen      <= '0;
            r_trend     <= TREND_NONE;
            r_swcnt     <= '0;
            r_out_valid <= 1'b0;
            r_rv        <= 1'b0;
            r_ev        <= 1'b0;
            r_sqv       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_head <= n_head;
                r_seen <= n_seen;
            end
            if (i_cmd.finish) begin
                r_trend     <= n_trend;
                r_swcnt     <= n_swcnt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_rv  <= i_cmd.rd;
            r_ev  <= r_rv & ~r_rfirst;
            r_sqv <= r_ev;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rfirst <= i_cmd.first;
        r_emag   <= e[SW-1] ? SW'(-e) : SW'(e);
        r_sq     <= (2 * SW)'(r_emag) * (2 * SW)'(r_emag);

        if (i_cmd.load) begin
            r_x     <= i_sample;
            r_raddr <= start_addr;
            r_sp_ok <= (n_seen >= p_c);
            r_more  <= (n_seen > p_c);
        end else if (i_cmd.rd) begin
            r_raddr <= raddr_inc;
        end

        if (i_cmd.load) begin
            r_s <= '0;
            r_q <= '0;
        end else begin
            if (r_rv && !r_rfirst) begin
                r_s <= r_s + SSW'(e);
            end
            if (r_sqv) begin
                r_q <= r_q + QW'(r_sq);
            end
        end

        // the oldest entry opens the running maximum
        if (r_rv) begin
            if (r_rfirst) begin
                r_o    <= e;
                r_last <= e;
                r_rsum <= '0;
            end else if (e > r_last) begin
                r_rsum <= r_rsum + RSW'(rise_d);
                r_last <= e;
            end
        end

        if (i_cmd.mul) begin
            r_pq     <= DW'(p) * DW'(r_q);
            r_ss     <= DW'(s_mag) * DW'(s_mag);
            r_o_zero <= (r_o == '0);
            r_flat   <= (r_x == r_o);
            r_neg    <= ((r_x > r_o) != (r_o > 0));
        end
        if (i_cmd.sub) begin
            r_d4 <= {r_pq - r_ss, 2'b00};
            r_lo <= '0;
        end
        if (i_cmd.sq_t) begin
            r_t <= TW'(odd) * TW'(p);
        end
        if (i_cmd.sq_s) begin
            r_tt <= (2 * TW)'(r_t) * (2 * TW)'(r_t);
        end
        if (i_cmd.sq_c && (CMPW'(r_tt) <= CMPW'(r_d4))) begin
            r_lo <= cand;
        end

        if (i_cmd.finish) begin
            r_spread   <= r_sp_ok ? r_lo : '0;
            r_rise_avg <= r_more ? rise_sat : '0;
            r_pct      <= r_more ? pct_sat : '0;
            r_switched <= sw_now;
            r_vflags   <= {r_sp_ok, r_more, r_more};
        end
    end

    assign o_walk_len      = p;
    assign o_stat.div_busy = busy_r | busy_c;
    assign o_stat.out_free = ~r_out_valid | i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {{PAD_W{1'b0}}, r_swcnt, r_switched, r_spread, r_pct,
                              r_rise_avg};
    assign o_m_tuser       = r_vflags;

endmodule

FILE: hdl/wts_ctrl.sv
// ----------------------------------------------------------------------------
// wts_ctrl
// Sequencer: accept, window walk, variance, bitwise root search, finish.
// ----------------------------------------------------------------------------
module wts_ctrl #(
    parameter int WINDOW_MAX = wts_pkg::WINDOW_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] i_walk_len,
    input  wts_pkg::t_stat                  i_stat,
    output wts_pkg::t_cmd                   o_cmd
);

    import wts_pkg::*;

    localparam int PW = $clog2(WINDOW_MAX + 1);

    t_state           r_state, n_state;
    logic [PW-1:0]    r_cnt, n_cnt;
    logic [1:0]       r_dcnt, n_dcnt;
    logic [SQB_W-1:0] r_bit, n_bit;
    logic             r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dcnt  <= '0;
            r_bit   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dcnt  <= n_dcnt;
            r_bit   <= n_bit;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_dcnt       = r_dcnt;
        n_bit        = r_bit;
        n_first      = r_first;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        o_cmd.sq_bit = r_bit;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = i_walk_len;
                    n_first    = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                // oldest entry first, newest last
                o_cmd.rd    = 1'b1;
                o_cmd.first = r_first;
                n_first     = 1'b0;
                if (r_cnt == '0) begin
                    n_dcnt  = 2'(DRAIN_LEN - 1);
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_dcnt == '0) begin
                    n_state = ST_MUL;
                end else begin
                    n_dcnt = r_dcnt - 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul       = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_SUB;
            end
            ST_SUB: begin
                o_cmd.sub = 1'b1;
                n_bit     = SQB_W'(RES_W - 1);
                n_state   = ST_SQ_T;
            end
            ST_SQ_T: begin
                o_cmd.sq_t = 1'b1;
                n_state    = ST_SQ_S;
            end
            ST_SQ_S: begin
                o_cmd.sq_s = 1'b1;
                n_state    = ST_SQ_C;
            end
            ST_SQ_C: begin
                o_cmd.sq_c = 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_WAIT;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = ST_SQ_T;
                end
            end
            ST_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_WALK))
        else $error("walk did not follow an accepted transfer");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result loaded while output register occupied");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider restarted while busy");

    a_root_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ_C && r_bit == '0) |=> (r_state == ST_WAIT))
        else $error("root search did not end after the last bit");

endmodule

FILE: hdl/window_trend_statistics_top.sv
// ----------------------------------------------------------------------------
// window_trend_statistics_top
// Sliding window standard deviation, percent change, rise average and
// trend reversal count over signed Q.8 samples.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                          | contents
//  config   | in        | i_cfg_we, i_cfg_data             | period
//  s stream | in        | i_s_tvalid/o_s_tready/i_s_tdata  | one sample
//  m stream | out       | o_m_tvalid/i_m_tready/o_m_tdata, | one result
//           |           | o_m_tuser                        |
//
//  one sample at a time (p = effective period): the next is accepted once
//  the last result is loaded; the bitwise square root search dominates,
//  after a walk of p + 1 ring reads through the single read port
//  the dividers run alongside the root search
//  synchronous active-low reset; the ring needs no clearing pass
//  a waiting result does not block the next sample
// ----------------------------------------------------------------------------
module window_trend_statistics_top #(
    parameter int WINDOW_MAX   = wts_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = wts_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wts_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // rise_average, change_percent, spread, switched, switch_total
    output logic [wts_pkg::OUT_DW-1:0]           o_m_tdata,
    // rise_valid, change_valid, spread_valid
    output logic [wts_pkg::OUT_UW-1:0]           o_m_tuser
);

    import wts_pkg::*;

    localparam int PW = $clog2(WINDOW_MAX + 1);

    t_cmd                   cmd;
    t_stat                  stat;
    logic [PW-1:0]          walk_len;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    assign sample = signed'(i_s_tdata[SAMPLE_WIDTH-1:0]);

    wts_ctrl #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_walk_len(walk_len),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    wts_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_sample  (sample),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_walk_len(walk_len),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule

FILE: tb/wts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_checker
// Watches the config, sample and result channels of the window trend
// statistics block, predicts every result and compares all of its fields.
// ----------------------------------------------------------------------------
module wts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [wts_pkg::OUT_DW-1:0] i_m_tdata,
    input  logic [2:0]  i_m_tuser,
    output int          o_errors,
    output int          o_pending
);
    import wts_pkg::*;

    typedef struct packed {
        logic [23:0] rise_average;
        logic [23:0] change_percent;
        logic [23:0] spread;
        logic        switched;
        logic [15:0] switch_total;
        logic        rise_valid;
        logic        change_valid;
        logic        spread_valid;
    } t_stats;

    t_stats    stats_q[$];
    logic [6:0] period_r;
    longint    ring[65];
    int        head_r;
    int        seen_r;
    t_trend    trend_r;
    int        reversals_r;

    function automatic longint ring_back(int k);
        return ring[(head_r + 65 - k) % 65];
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_stats predict_stats(logic [23:0] raw);
        t_stats r;
        longint x, o, last, sum, avg, pct, num, an, ao, s, q, d4, lo, hi, mid, t;
        int p, sgn;
        t_trend cur;
        r = '0;
        x = longint'($signed(raw));
        p = period_r < 1 ? 1 : (period_r > 64 ? 64 : int'(period_r));
        head_r = (head_r + 1) % 65;
        ring[head_r] = x;
        if (seen_r < p + 1) seen_r++;
        if (seen_r > p + 1) seen_r = p + 1;
        if (seen_r >= p) begin
            s = 0;
            q = 0;
            for (int k = 0; k < p; k++) begin
                s += ring_back(k);
                q += ring_back(k) * ring_back(k);
            end
            d4 = (p * q - s * s) * 4;
            lo = 0;
            hi = 24'hffffff;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                t = (2 * mid - 1) * p;
                if (t * t <= d4) lo = mid;
                else hi = mid - 1;
            end
            r.spread_valid = 1'b1;
            r.spread = lo[23:0];
        end
        if (seen_r > p) begin
            o = ring_back(p);
            last = o;
            sum = 0;
            for (int k = p - 1; k >= 0; k--) begin
                if (ring_back(k) > last) begin
                    sum += ring_back(k) - last;
                    last = ring_back(k);
                end
            end
            avg = (2 * sum + p) / (2 * p);
            r.rise_valid = 1'b1;
            r.rise_average = avg > 24'hffffff ? 24'hffffff : avg[23:0];
            if (o == 0) begin
                pct = 100;
                sgn = 1;
            end else begin
                num = (x - o) * 100;
                an = absl(num);
                ao = absl(o);
                if (num == 0) sgn = 0;
                else sgn = ((num > 0) == (o > 0)) ? 1 : -1;
                pct = (2 * an + ao) / (2 * ao);
            end
            if (sgn < 0) begin
                if (pct > 8388608) pct = 8388608;
                r.change_percent = 24'(-pct);
            end else begin
                if (pct > 8388607) pct = 8388607;
                r.change_percent = pct[23:0];
            end
            r.change_valid = 1'b1;
            cur = sgn == 0 ? TREND_NONE : (sgn > 0 ? TREND_RISE : TREND_FALL);
            if (cur != TREND_NONE) begin
                if (trend_r != TREND_NONE && cur != trend_r) begin
                    trend_r = cur;
                    if (reversals_r < 65535) reversals_r++;
                    r.switched = 1'b1;
                end else if (trend_r == TREND_NONE) begin
                    trend_r = cur;
                end
            end
        end
        r.switch_total = reversals_r[15:0];
        return r;
    endfunction

    assign o_pending = stats_q.size();

    always @(posedge i_clk) begin
        t_stats got, want;
        if (!i_rst_n) begin
            period_r    <= PERIOD_RST;
            head_r      = 0;
            seen_r      = 0;
            trend_r     = TREND_NONE;
            reversals_r = 0;
            o_errors    <= 0;
            stats_q.delete();
        end else begin
            if (i_cfg_we) period_r <= i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                stats_q.insert(stats_q.size(), predict_stats(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.rise_average   = i_m_tdata[23:0];
                got.change_percent = i_m_tdata[47:24];
                got.spread         = i_m_tdata[71:48];
                got.switched       = i_m_tdata[72];
                got.switch_total   = i_m_tdata[88:73];
                got.rise_valid     = i_m_tuser[0];
                got.change_valid   = i_m_tuser[1];
                got.spread_valid   = i_m_tuser[2];
                if (stats_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = stats_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples through the window trend statistics block under several
// periods with random idling and back pressure; a checker predicts results.
// ----------------------------------------------------------------------------
module testbench;
    import wts_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_tdata;
    logic [OUT_UW-1:0] o_m_tuser;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          quiet_sink = 1'b0;
    bit          hold_sink = 1'b0;

    localparam int STALL_LIMIT = 20000;

    always #10 i_clk = ~i_clk;

    window_trend_statistics_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    wts_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .o_errors(errors), .o_pending(pending)
    );

    // result side: random idling, optional long hold-off
    always @(posedge i_clk) begin
        if (hold_sink) i_m_tready <= 1'b0;
        else if (quiet_sink) i_m_tready <= 1'b1;
        else i_m_tready <= $urandom_range(99) >= 14;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || hold_sink)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // tvalid stays up after the transfer; the next call or the caller drops it
    task automatic send_sample(logic [23:0] v, bit idle);
        while (idle && $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain_and_set(logic [6:0] p);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= p;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [23:0] rand_sample(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(2000)) - 1000);
            2: return ($urandom_range(1) != 0) ? 24'(24'h7fffff - $urandom_range(3))
                                               : 24'(24'h800000 + $urandom_range(3));
            default: return $urandom_range(3) == 0 ? 24'h0 : 24'($urandom_range(40) * 256);
        endcase
    endfunction

    initial begin
        logic [6:0] periods[8] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd16, 7'd2, 7'd9};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, zero reference, zero change, reversals
        foreach (periods[i]) begin end
        send_sample(24'h000000, 1'b0);
        send_sample(24'h7fffff, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h000100, 1'b0);
        send_sample(24'h000100, 1'b0);
        send_sample(24'hffff00, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'h000200, 1'b0);
        send_sample(24'h7fffff, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h800000, 1'b0);
        drain_and_set(7'd1);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h7fffff, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h555555, 1'b0);
        send_sample(24'haaaaaa, 1'b0);
        send_sample(24'haaaaaa, 1'b0);
        drain_and_set(7'd64);
        for (int i = 0; i < 70; i++) send_sample(rand_sample(i % 4), 1'b1);
        // period lowered mid-stream clamps the count
        drain_and_set(7'd2);
        for (int i = 0; i < 20; i++) send_sample(rand_sample(3), 1'b1);
        // long hold-off on the result side while samples keep coming
        fork
            begin
                hold_sink = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 10; i++) send_sample(rand_sample(1), 1'b0);
        join
        foreach (periods[k]) begin
            drain_and_set(periods[k]);
            quiet_sink = (k == 5);
            for (int i = 0; i < 90; i++) send_sample(rand_sample($urandom_range(3)), k != 5);
        end
        quiet_sink = 1'b0;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end
endmodule

FILE: window_trend_statistics_top.f
hdl/wts_pkg.sv
hdl/wts_ram.sv
hdl/wts_div.sv
hdl/wts_datapath.sv
hdl/wts_ctrl.sv
hdl/window_trend_statistics_top.sv
tb/wts_checker.sv
tb/testbench.sv
